// ----- rtl/fct_pkg.sv -----
// fct_pkg: shared types, widths and codes for the frustum cull test block
// no dependencies; used by the interfaces, fct_cell and frustum_cull_test

package fct_pkg;

	localparam int unsigned NUM_REGS       = 6;
	localparam int unsigned PLANE_COUNT_DEF = 6;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned CFG_DATA_W     = 64;
	localparam int unsigned COORD_W        = 16;
	localparam int unsigned RAD_W          = 15;
	localparam int unsigned PROD_W         = 2 * COORD_W;
	localparam int unsigned DIST_W         = PROD_W + 2;
	localparam int unsigned FRAC_SHIFT     = 14;
	localparam int unsigned BOX_BIT        = 1;

	localparam logic [1:0] OP_POINT  = 2'd0;
	localparam logic [1:0] OP_SPHERE = 2'd1;
	localparam logic [1:0] OP_BOX    = 2'd2;

	typedef enum logic [1:0] {
		CLS_INSIDE    = 2'd0,
		CLS_INTERSECT = 2'd1,
		CLS_OUTSIDE   = 2'd2
	} cls_e;

	typedef struct packed {
		logic [1:0]                operation;
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic [RAD_W-1:0]          radius;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
	} req_t;

	typedef struct packed {
		cls_e classification;
	} res_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic valid;
		req_t req;
		logic outside;
		logic isect;
	} item_t;

endpackage

// ----- rtl/fct_req_if.sv -----
// fct_req_if: request channel, valid/ready with a req_t payload
// depends on fct_pkg

interface fct_req_if import fct_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/fct_res_if.sv -----
// fct_res_if: result channel, valid/ready with a res_t payload
// depends on fct_pkg

interface fct_res_if import fct_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/fct_cell.sv -----
// fct_cell: one plane of the chain; holds the plane register, multiplies in
// stage one, sums and compares in stage two; depends on fct_pkg

module fct_cell import fct_pkg::*; #(
	parameter int unsigned INDEX = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  cfg_wr_t cfg,
	input  item_t   in_item,
	output item_t   out_item
);

	localparam bit WRITABLE = (INDEX < NUM_REGS);

	logic [CFG_DATA_W-1:0] plane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (WRITABLE && cfg.we && cfg.idx == CFG_IDX_W'(INDEX)) begin
			plane_q <= cfg.data;
		end
	end

	logic signed [COORD_W-1:0] ca, cb, cc, cd;
	assign ca = $signed(plane_q[15:0]);
	assign cb = $signed(plane_q[31:16]);
	assign cc = $signed(plane_q[47:32]);
	assign cd = $signed(plane_q[63:48]);

	// stage one: products against both corners
	item_t                     item_s1;
	logic signed [PROD_W-1:0]  plx_s1, phx_s1, ply_s1, phy_s1, plz_s1, phz_s1;
	logic signed [COORD_W-1:0] d_s1;
	logic                      pa_s1, pb_s1, pc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (adv) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plx_s1 <= PROD_W'(ca * in_item.req.min_x);
			phx_s1 <= PROD_W'(ca * in_item.req.max_x);
			ply_s1 <= PROD_W'(cb * in_item.req.min_y);
			phy_s1 <= PROD_W'(cb * in_item.req.max_y);
			plz_s1 <= PROD_W'(cc * in_item.req.min_z);
			phz_s1 <= PROD_W'(cc * in_item.req.max_z);
			d_s1   <= cd;
			pa_s1  <= ~ca[COORD_W-1];
			pb_s1  <= ~cb[COORD_W-1];
			pc_s1  <= ~cc[COORD_W-1];
		end
	end

	// stage two: distances and compares
	logic                     box, sphere;
	logic                     ux, uy, uz;
	logic signed [DIST_W-1:0] off, rad, dp, dn;
	logic                     out_hit, isect_hit;
	item_t                    nxt_item;

	always_comb begin
		box    = item_s1.req.operation[BOX_BIT];
		sphere = (item_s1.req.operation == OP_SPHERE);
		ux     = box && pa_s1;
		uy     = box && pb_s1;
		uz     = box && pc_s1;
		off    = DIST_W'(d_s1) <<< FRAC_SHIFT;
		rad    = $signed(DIST_W'({1'b0, item_s1.req.radius}) << FRAC_SHIFT);
		dp     = DIST_W'(ux ? phx_s1 : plx_s1) + DIST_W'(uy ? phy_s1 : ply_s1)
		       + DIST_W'(uz ? phz_s1 : plz_s1) + off;
		dn     = DIST_W'(pa_s1 ? plx_s1 : phx_s1) + DIST_W'(pb_s1 ? ply_s1 : phy_s1)
		       + DIST_W'(pc_s1 ? plz_s1 : phz_s1) + off;
		out_hit   = sphere ? (dp < -rad) : (dp < 0);
		isect_hit = box ? (dn < 0) : (sphere && dp < rad);
		nxt_item         = item_s1;
		nxt_item.outside = item_s1.outside | out_hit;
		nxt_item.isect   = item_s1.isect | isect_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_item <= '0;
		end else if (adv) begin
			out_item <= nxt_item;
		end
	end

endmodule

// ----- rtl/frustum_cull_test.sv -----
// frustum_cull_test: an accepted request passes both registered stages of each plane
// cell, then the result register; one request per cycle sustained while results are
// taken, set by the two-stage cell per plane and the shared advance of the whole chain
// the chain stalls as a whole only while the result register waits to be taken
// reset clears all plane registers to zero and empties the pipeline
// depends on fct_pkg, fct_req_if, fct_res_if, fct_cell

module frustum_cull_test import fct_pkg::*; #(
	parameter int unsigned PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fct_req_if.sink               req,
	fct_res_if.source             res
);

	localparam int unsigned LAT   = 2 * PLANE_COUNT + 1;
	localparam int unsigned INF_W = $clog2(LAT + 1);

	logic    adv;
	cfg_wr_t cfg;
	item_t   chain [PLANE_COUNT+1];
	logic    res_valid_q;
	cls_e    res_cls_q;

	assign adv       = !res_valid_q || res.ready;
	assign req.ready = adv;
	assign cfg       = '{we: cfg_we, idx: cfg_index, data: cfg_data};
	assign chain[0]  = '{valid: req.valid, req: req.data, outside: 1'b0, isect: 1'b0};

	for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
		fct_cell #(.INDEX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cfg      (cfg),
			.in_item  (chain[i]),
			.out_item (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= chain[PLANE_COUNT].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			priority if (chain[PLANE_COUNT].outside) begin
				res_cls_q <= CLS_OUTSIDE;
			end else if (chain[PLANE_COUNT].isect) begin
				res_cls_q <= CLS_INTERSECT;
			end else begin
				res_cls_q <= CLS_INSIDE;
			end
		end
	end

	assign res.valid               = res_valid_q;
	assign res.data.classification = res_cls_q;

	// requests in flight, for checking only
	logic [INF_W-1:0] inflight_q;
	logic             acc_in, acc_out;

	assign acc_in  = req.valid && req.ready;
	assign acc_out = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (acc_in && !acc_out) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (acc_out && !acc_in) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> $stable(chain[PLANE_COUNT]))
		else $error("chain moved while result stalled");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= INF_W'(LAT))
		else $error("more requests in flight than pipeline depth");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> inflight_q != '0)
		else $error("result without an accepted request");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// testbench: frustum_cull_test checked against its own classifier over point, sphere and box
// requests under several plane settings, with random gaps on both channels
// depends on fct_pkg, fct_req_if, fct_res_if and frustum_cull_test

module testbench;
	import fct_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [CFG_DATA_W-1:0] plane_t;
	typedef enum {SET_ZERO, SET_BOX, SET_MAXED, SET_MINED, SET_EXTREME, SET_RANDOM, SET_TILTED}
		plane_set_e;

	localparam int REG_NEAR   = 0;
	localparam int REG_FAR    = 1;
	localparam int REG_LEFT   = 2;
	localparam int REG_RIGHT  = 3;
	localparam int REG_TOP    = 4;
	localparam int REG_BOTTOM = 5;

	localparam logic [1:0] OP_BOX_ALT = 2'd3;
	localparam logic signed [15:0] ONE     = 16'sh4000;
	localparam logic signed [15:0] NEG_ONE = 16'shC000;
	localparam int LATENCY      = 2 * PLANE_COUNT_DEF + 1;
	localparam int HOLD_CYCLES  = 200;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 100;

	class cull_scoreboard;
		plane_t planes [PLANE_COUNT_DEF];
		cls_e expected_cls [$];
		int mismatches;
		int requests;
		int results;
		int cls_hits [3];

		function new();
			foreach (planes[i]) planes[i] = '0;
			mismatches = 0;
			requests = 0;
			results = 0;
			foreach (cls_hits[i]) cls_hits[i] = 0;
		endfunction

		function void set_plane(int unsigned idx, plane_t value);
			if (idx < NUM_REGS) planes[idx] = value;
		endfunction

		function longint coef(plane_t p, int k);
			return longint'($signed(p[16*k +: 16]));
		endfunction

		function longint distance(plane_t p, longint x, longint y, longint z);
			return coef(p, 0) * x + coef(p, 1) * y + coef(p, 2) * z
				+ (coef(p, 3) << FRAC_SHIFT);
		endfunction

		function cls_e classify(req_t r);
			longint lx, ly, lz, hx, hy, hz, rad, d, pos_d, neg_d;
			plane_t p;
			bit outside, isect, pa, pb, pc;
			lx = longint'($signed(r.min_x));
			ly = longint'($signed(r.min_y));
			lz = longint'($signed(r.min_z));
			hx = longint'($signed(r.max_x));
			hy = longint'($signed(r.max_y));
			hz = longint'($signed(r.max_z));
			rad = longint'(r.radius) << FRAC_SHIFT;
			outside = 0;
			isect = 0;
			for (int i = 0; i < PLANE_COUNT_DEF; i++) begin
				p = planes[i];
				if (r.operation[BOX_BIT]) begin
					pa = coef(p, 0) >= 0;
					pb = coef(p, 1) >= 0;
					pc = coef(p, 2) >= 0;
					pos_d = distance(p, pa ? hx : lx, pb ? hy : ly, pc ? hz : lz);
					neg_d = distance(p, pa ? lx : hx, pb ? ly : hy, pc ? lz : hz);
					if (pos_d < 0) outside = 1;
					else if (neg_d < 0) isect = 1;
				end else if (r.operation == OP_SPHERE) begin
					d = distance(p, lx, ly, lz);
					if (d < -rad) outside = 1;
					else if (d < rad) isect = 1;
				end else if (distance(p, lx, ly, lz) < 0) begin
					outside = 1;
				end
			end
			if (outside) return CLS_OUTSIDE;
			return isect ? CLS_INTERSECT : CLS_INSIDE;
		endfunction

		function void note_request(req_t r);
			expected_cls.push_back(classify(r));
			requests++;
		endfunction

		function void check_result(res_t got);
			cls_e want;
			results++;
			if (expected_cls.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d with no request outstanding",
						got.classification);
				return;
			end
			want = expected_cls.pop_front();
			cls_hits[want]++;
			if (got.classification !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("classification mismatch on result %0d: expected %0d got %0d",
						results, want, got.classification);
			end
		endfunction

		function int pending();
			return expected_cls.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fct_req_if request_ch ();
	fct_res_if result_ch ();

	cull_scoreboard sb = new();

	bit source_idle_on = 0;
	bit sink_stall_on = 0;
	bit hold_pending = 0;
	int plane_sets = 0;

	frustum_cull_test dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (request_ch),
		.res       (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
	endfunction

	function automatic plane_t pack_plane(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d);
		return {d, c, b, a};
	endfunction

	function automatic logic [15:0] extreme_field();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [15:0] unit_field();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic plane_t plane_value(plane_set_e kind, int idx, int half);
		logic [15:0] h;
		h = 16'(half);
		case (kind)
			SET_ZERO: return '0;
			SET_MAXED: return {4{16'h7FFF}};
			SET_MINED: return {4{16'h8000}};
			SET_EXTREME: return pack_plane(extreme_field(), extreme_field(), extreme_field(),
				extreme_field());
			SET_RANDOM: return {$urandom, $urandom};
			SET_TILTED: return pack_plane(unit_field(), unit_field(), unit_field(),
				16'($signed($urandom_range(0, 16384)) - 8192));
			default: begin
				case (idx)
					REG_NEAR: return pack_plane(0, 0, ONE, h);
					REG_FAR: return pack_plane(0, 0, NEG_ONE, h);
					REG_LEFT: return pack_plane(ONE, 0, 0, h);
					REG_RIGHT: return pack_plane(NEG_ONE, 0, 0, h);
					REG_TOP: return pack_plane(0, NEG_ONE, 0, h);
					default: return pack_plane(0, ONE, 0, h);
				endcase
			end
		endcase
	endfunction

	task automatic write_reg(int unsigned idx, plane_t value);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= value;
		@(posedge clk);
		sb.set_plane(idx, value);
	endtask

	task automatic load_planes(plane_set_e kind, int half);
		for (int i = 0; i < NUM_REGS; i++) write_reg(i, plane_value(kind, i, half));
		// indexes past the last plane must be dropped
		write_reg(NUM_REGS + $urandom_range(0, 1), {$urandom, $urandom});
		cfg_we <= 1'b0;
		@(posedge clk);
		plane_sets++;
	endtask

	function automatic req_t make_req(logic [1:0] op, coord_t lx, coord_t ly, coord_t lz,
			logic [RAD_W-1:0] rad, coord_t hx, coord_t hy, coord_t hz);
		req_t r;
		r.operation = op;
		r.min_x = lx;
		r.min_y = ly;
		r.min_z = lz;
		r.radius = rad;
		r.max_x = hx;
		r.max_y = hy;
		r.max_z = hz;
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2, 3: return coord_t'($urandom);
			default: return coord_t'($signed($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	function automatic coord_t span_from(coord_t lo);
		int hi;
		if ($urandom_range(0, 9) == 0) return coord_t'($urandom);
		hi = int'(lo) + int'($urandom_range(0, 1200));
		return (hi > 32767) ? 16'sh7FFF : coord_t'(hi);
	endfunction

	function automatic req_t rand_req();
		logic [1:0] op;
		coord_t lx, ly, lz;
		logic [RAD_W-1:0] rad;
		case ($urandom_range(0, 9))
			0: op = OP_BOX_ALT;
			1, 2, 3: op = OP_POINT;
			4, 5, 6: op = OP_SPHERE;
			default: op = OP_BOX;
		endcase
		lx = rand_coord();
		ly = rand_coord();
		lz = rand_coord();
		rad = ($urandom_range(0, 9) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 900));
		return make_req(op, lx, ly, lz, rad, span_from(lx), span_from(ly), span_from(lz));
	endfunction

	task automatic send_request(req_t item);
		int gap;
		gap = (source_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.data <= item;
		do @(posedge clk); while (!request_ch.ready);
	endtask

	task automatic drain();
		request_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (request_ch.valid && request_ch.ready) sb.note_request(request_ch.data);
			if (result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
		end
	end

	// result side: random stalls plus one long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (hold_pending) begin
				hold_pending = 0;
				stall_left = HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
				stall_left = pick_gap() - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		request_ch.valid = 1'b0;
		request_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// planes still at reset: every distance is zero
		send_request(make_req(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_req(OP_SPHERE, 5, -5, 7, 0, 0, 0, 0));
		send_request(make_req(OP_SPHERE, 5, -5, 7, 3, 0, 0, 0));
		send_request(make_req(OP_BOX, -10, -10, -10, 0, 10, 10, 10));
		drain();

		// axis-aligned frustum, half size 1600 coordinate units
		load_planes(SET_BOX, 1600);
		send_request(make_req(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_req(OP_POINT, 1601, 0, 0, 0, 0, 0, 0));
		send_request(make_req(OP_POINT, 1600, -1600, 1600, 0, 0, 0, 0));
		send_request(make_req(OP_POINT, 16'sh8000, 16'sh7FFF, 0, RAD_W'(32767),
			16'sh8000, 16'sh7FFF, -1));
		send_request(make_req(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_req(OP_SPHERE, 1500, 0, 0, 200, 0, 0, 0));
		send_request(make_req(OP_SPHERE, 1900, 0, 0, 200, 0, 0, 0));
		send_request(make_req(OP_SPHERE, 1800, 0, 0, 200, 0, 0, 0));
		send_request(make_req(OP_SPHERE, 0, 0, 0, RAD_W'(32767), 0, 0, 0));
		send_request(make_req(OP_BOX, -100, -100, -100, 0, 100, 100, 100));
		send_request(make_req(OP_BOX, 1500, -100, -100, 0, 1700, 100, 100));
		send_request(make_req(OP_BOX, 1700, 0, 0, 0, 1800, 10, 10));
		// inverted extents are taken as given
		send_request(make_req(OP_BOX, 100, 100, 100, 0, -100, -100, -100));
		send_request(make_req(OP_BOX_ALT, 1500, -100, -100, 0, 1700, 100, 100));
		send_request(make_req(OP_BOX, 16'sh8000, 16'sh8000, 16'sh8000, 0,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		drain();

		load_planes(SET_MAXED, 0);
		send_request(make_req(OP_POINT, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0));
		send_request(make_req(OP_SPHERE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, RAD_W'(32767),
			0, 0, 0));
		send_request(make_req(OP_BOX, 16'sh8000, 16'sh8000, 16'sh8000, 0,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		drain();

		load_planes(SET_MINED, 0);
		send_request(make_req(OP_POINT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0));
		send_request(make_req(OP_SPHERE, 16'sh8000, 16'sh8000, 16'sh8000, RAD_W'(32767),
			0, 0, 0));
		send_request(make_req(OP_BOX_ALT, 16'sh8000, 16'sh8000, 16'sh8000, 0,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			source_idle_on = (phase >= 2);
			sink_stall_on = (phase == 1 || phase == 2);
			hold_pending = (phase == 1);
			case (phase)
				0: load_planes(SET_BOX, $urandom_range(64, 3200));
				1: load_planes(SET_TILTED, 0);
				2: load_planes(SET_EXTREME, 0);
				default: load_planes(SET_RANDOM, 0);
			endcase
			repeat (PHASE_ITEMS) begin
				send_request(rand_req());
				if (phase == 0 && $urandom_range(0, 7) == 0) source_idle_on = !source_idle_on;
			end
			drain();
		end

		$display("%0d requests and %0d results over %0d plane settings", sb.requests,
			sb.results, plane_sets);
		$display("inside %0d, intersecting %0d, outside %0d, mismatches %0d",
			sb.cls_hits[CLS_INSIDE], sb.cls_hits[CLS_INTERSECT], sb.cls_hits[CLS_OUTSIDE],
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
